// ===== rtl/gha_pkg.sv =====
// Shared constants, codes and types of the generational handle allocator.
// No dependencies; gha_alu and the top module import this package.
package gha_pkg;

  localparam int INDEX_BITS = 10;
  localparam int GEN_BITS   = 12;
  localparam int CNT_BITS   = INDEX_BITS + 1;
  localparam int SLOT_MAX   = 1 << INDEX_BITS;
  localparam int ALU_BITS   = (CNT_BITS > GEN_BITS) ? CNT_BITS : GEN_BITS;
  localparam int OP_BITS    = 2;

  // slot store word: live mark above the generation
  localparam int SLOT_BITS  = GEN_BITS + 1;

  localparam logic [OP_BITS-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_QUERY   = 2'd2;

  localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);

  typedef struct packed {
    logic                lt;
    logic                eq;
    logic [ALU_BITS-1:0] inc;
  } alu_res_t;

endpackage

// ===== rtl/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the slot store and the free stack.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gha_alu.sv =====
// Shared compare / increment unit, reused by each step of the sequencer.
// Depends on gha_pkg.
module gha_alu (
  input  logic [gha_pkg::ALU_BITS-1:0] a,
  input  logic [gha_pkg::ALU_BITS-1:0] b,
  output gha_pkg::alu_res_t            res
);
  import gha_pkg::*;

  always_comb begin
    res.lt  = (a < b);
    res.eq  = (a == b);
    res.inc = a + ALU_BITS'(1);
  end

endmodule

// ===== rtl/generational_handle_allocator_top.sv =====
// Generational handle allocator: sequencer, counters and the two stores.
// Depends on gha_pkg, gha_ram and gha_alu.

// Each request (create, release, query alive) takes two dependent memory reads before its
// result reaches the output register: the free-stack top is read at acceptance, the slot
// store is read at the index that read picks, then the update and result follow. No new
// request is taken until the last one has left the update step, as s_tready is high only
// while the sequencer is idle. A result waits in an output register, so the next request
// can be taken before the result is consumed; the update step holds off while an old
// result still waits. Slot state beyond the fresh-slot counter is treated as never used,
// so no clearing pass is needed after reset. slot_count may be written only while the
// block is idle.
module generational_handle_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gha_pkg::CNT_BITS-1:0]  cfg_wdata,   // slot_count
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,     // req_index[9:0], req_gen[21:10], zeros
  input  logic [1:0]                    s_tuser,     // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata      // ok, new_index, new_gen, live_total, zeros
);
  import gha_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]            state;
  logic [OP_BITS-1:0]    op_r;
  logic [INDEX_BITS-1:0] ridx_r;
  logic [GEN_BITS-1:0]   rgen_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic                  cand_ok;     // candidate index below capacity
  logic                  popped;      // create candidate came from the free stack
  logic                  written;     // candidate index below fresh_next
  logic [CNT_BITS-1:0]   slot_count;
  logic [CNT_BITS-1:0]   free_depth;
  logic [CNT_BITS-1:0]   fresh_next;
  logic [CNT_BITS-1:0]   live_tally;

  logic                  out_ok;
  logic [INDEX_BITS-1:0] out_index;
  logic [GEN_BITS-1:0]   out_gen;
  logic [CNT_BITS-1:0]   out_total;

  logic [CNT_BITS-1:0]   cap;
  logic [INDEX_BITS-1:0] stack_q;
  logic [SLOT_BITS-1:0]  slot_q;
  logic [CNT_BITS-1:0]   cand;
  logic [INDEX_BITS-1:0] cand_idx;
  logic                  live_v;
  logic [GEN_BITS-1:0]   gen_v;
  logic [GEN_BITS-1:0]   gen_create;
  logic [GEN_BITS-1:0]   gen_bump;
  logic                  is_create;
  logic                  is_release;
  logic                  got;
  logic                  rel;
  logic                  alive;
  logic                  exec_go;
  logic                  slot_we;
  logic [SLOT_BITS-1:0]  slot_wdata;
  logic [ALU_BITS-1:0]   alu_a;
  logic [ALU_BITS-1:0]   alu_b;
  alu_res_t              alu_res;

  logic                  s_fire;
  logic [CNT_BITS-1:0]   free_depth_next;
  logic [CNT_BITS-1:0]   fresh_next_next;
  logic [CNT_BITS-1:0]   live_tally_next;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign cap      = (slot_count > CNT_BITS'(SLOT_MAX)) ? CNT_BITS'(SLOT_MAX) : slot_count;

  // read step: pick the candidate index
  assign is_create = (op_r == OP_CREATE);
  always_comb begin
    if (is_create && (free_depth == '0)) begin
      cand = fresh_next;
    end else if (is_create) begin
      cand = {1'b0, stack_q};
    end else begin
      cand = {1'b0, ridx_r};
    end
  end
  assign cand_idx = cand[INDEX_BITS-1:0];

  // exec step: slot contents, with never-used slots read as zero
  assign live_v     = written && slot_q[GEN_BITS];
  assign gen_v      = written ? slot_q[GEN_BITS-1:0] : '0;
  assign gen_create = (gen_v == '0) ? GEN_ONE : gen_v;
  assign gen_bump   = (alu_res.inc[GEN_BITS-1:0] == '0) ? GEN_ONE : alu_res.inc[GEN_BITS-1:0];

  assign alu_a = (state == ST_READ) ? ALU_BITS'(cand) : ALU_BITS'(gen_v);
  assign alu_b = (state == ST_READ) ? ALU_BITS'(cap)  : ALU_BITS'(rgen_r);

  gha_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign is_release = (op_r == OP_RELEASE);
  assign exec_go    = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign got        = cand_ok && (!popped || !live_v);
  assign alive      = (rgen_r != '0) && cand_ok && live_v && alu_res.eq;
  assign rel        = alive && (free_depth < cap) && (live_tally != '0);
  assign slot_we    = exec_go && ((is_create && got) || (is_release && rel));
  assign slot_wdata = is_create ? {1'b1, gen_create} : {1'b0, gen_bump};

  gha_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (SLOT_MAX)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (idx_r),
    .wdata (slot_wdata),
    .re    (state == ST_READ),
    .raddr (cand_idx),
    .rdata (slot_q)
  );

  gha_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (SLOT_MAX)
  ) u_stack_ram (
    .clk   (clk),
    .we    (exec_go && is_release && rel),
    .waddr (free_depth[INDEX_BITS-1:0]),
    .wdata (ridx_r),
    .re    (s_fire),
    .raddr (INDEX_BITS'(free_depth - CNT_BITS'(1))),
    .rdata (stack_q)
  );

  always_comb begin
    free_depth_next = free_depth;
    fresh_next_next = fresh_next;
    live_tally_next = live_tally;
    if (is_create && got) begin
      if (popped) begin
        free_depth_next = free_depth - CNT_BITS'(1);
      end else begin
        fresh_next_next = fresh_next + CNT_BITS'(1);
      end
      live_tally_next = live_tally + CNT_BITS'(1);
    end else if (is_release && rel) begin
      free_depth_next = free_depth + CNT_BITS'(1);
      live_tally_next = live_tally - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_count <= CNT_BITS'(SLOT_MAX);
      free_depth <= '0;
      fresh_next <= '0;
      live_tally <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_count <= cfg_wdata;
      end
      // a new result may replace one taken at the same edge
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            free_depth <= free_depth_next;
            fresh_next <= fresh_next_next;
            live_tally <= live_tally_next;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_r   <= s_tuser;
      ridx_r <= s_tdata[INDEX_BITS-1:0];
      rgen_r <= s_tdata[INDEX_BITS +: GEN_BITS];
    end
    if (state == ST_READ) begin
      idx_r   <= cand_idx;
      cand_ok <= alu_res.lt;
      popped  <= (free_depth != '0);
      written <= (cand < fresh_next);
    end
    if (exec_go) begin
      out_total <= live_tally_next;
      if (is_create) begin
        out_ok    <= got;
        out_index <= got ? idx_r : '0;
        out_gen   <= got ? gen_create : '0;
      end else begin
        out_ok    <= (is_release && rel) || ((op_r == OP_QUERY) && alive);
        out_index <= '0;
        out_gen   <= '0;
      end
    end
  end

  assign m_tdata = {6'd0, out_total, out_gen, out_index, out_ok};

`ifndef ASSERT_OFF
  // every created slot is either live or sitting on the free stack
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, live_tally} + {1'b0, free_depth}) == {1'b0, fresh_next})
    else $error("live plus free slots differ from slots handed out");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= CNT_BITS'(SLOT_MAX))
    else $error("fresh slot counter past the slot store");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EXEC))
    else $error("result appeared outside the update step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_EXEC))
    else $error("sequencer skipped the update step");
`endif

endmodule
